/* hw/rtl/smbhc_pkg.sv */
// Shared types and constants for the SMBus host controller register file.
// Used by the register file core, the top level and the port checker.
package smbhc_pkg;

  localparam int unsigned BLOCK_BYTES = 32;
  localparam int unsigned IDX_W = $clog2(BLOCK_BYTES);

  typedef enum logic [2:0] {
    KIND_REG_WRITE = 3'd0,
    KIND_REG_READ  = 3'd1,
    KIND_BUS_DONE  = 3'd2,
    KIND_BUF_STORE = 3'd3,
    KIND_BUF_FETCH = 3'd4
  } kind_e;

  // Register offsets inside the I/O window.
  localparam logic [5:0] REG_STATUS  = 6'd0;
  localparam logic [5:0] REG_CONTROL = 6'd2;
  localparam logic [5:0] REG_ADDRESS = 6'd4;
  localparam logic [5:0] REG_DATA0   = 6'd6;
  localparam logic [5:0] REG_DATA1   = 6'd7;
  localparam logic [5:0] REG_COMMAND = 6'd8;
  localparam logic [5:0] REG_BLOCK   = 6'd9;

  // Status bits.
  localparam logic [7:0] ST_ABORT     = 8'h01;
  localparam logic [7:0] ST_PRERR     = 8'h04;
  localparam logic [7:0] ST_DONE      = 8'h10;
  localparam logic [7:0] ST_CLEARABLE = 8'h37;

  // Control bits.
  localparam int unsigned CT_START_BIT = 3;
  localparam int unsigned CT_IRQEN_BIT = 4;
  localparam int unsigned CT_ABORT_BIT = 5;
  localparam logic [7:0]  CT_READ_MASK = 8'h1f;

  // Protocol codes.
  localparam logic [2:0] PROTO_QUICK = 3'd0;
  localparam logic [2:0] PROTO_WORD  = 3'd3;
  localparam logic [2:0] PROTO_BLOCK = 3'd5;

  localparam int unsigned S_DATA_W = 40;
  localparam int unsigned M_DATA_W = 56;

  typedef struct packed {
    kind_e       kind;
    logic [5:0]  offset;
    logic [7:0]  value;
    logic        bus_ok;
    logic [15:0] bus_data;
    logic [4:0]  buf_position;
  } item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        irq_level;
    logic        start_request;
    logic [2:0]  req_protocol;
    logic [6:0]  req_device;
    logic        req_read;
    logic [7:0]  req_command;
    logic [15:0] req_word;
    logic [7:0]  req_block_len;
  } result_t;

endpackage

/* hw/rtl/smbhc_regfile.sv */
// Register file core of the SMBus host controller: register state, block
// buffer and the per-beat update logic. Depends on smbhc_pkg.
module smbhc_regfile (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  smbhc_pkg::item_t   item_i,
  output smbhc_pkg::result_t result_o
);
  import smbhc_pkg::*;

  logic [7:0]     status_q, status_d;
  logic [7:0]     control_q, control_d;
  logic [7:0]     command_q, command_d;
  logic [7:0]     address_q, address_d;
  logic [7:0]     data0_q, data0_d;
  logic [7:0]     data1_q, data1_d;
  logic [IDX_W-1:0] index_q, index_d;
  logic           irq_q, irq_d;
  logic           busy_q, busy_d;
  logic [7:0]     blk_mem_q [BLOCK_BYTES];

  logic             blk_we;
  logic [IDX_W-1:0] blk_waddr;
  logic [IDX_W-1:0] blk_raddr;
  logic [7:0]       blk_rdata;
  logic [IDX_W-1:0] index_next;
  logic [7:0]       st;
  logic [7:0]       rd;
  logic             start;
  logic             proto_ok;

  function automatic logic proto_supported(logic [2:0] p);
    return (p <= PROTO_WORD) || (p == PROTO_BLOCK);
  endfunction

  assign index_next = (index_q == IDX_W'(BLOCK_BYTES - 1)) ? '0 : index_q + 1'b1;
  assign blk_raddr  = (item_i.kind == KIND_BUF_FETCH) ? item_i.buf_position : index_q;
  assign blk_rdata  = blk_mem_q[blk_raddr];
  assign proto_ok   = proto_supported(item_i.value[2:0]);

  always_comb begin
    status_d  = status_q;
    control_d = control_q;
    command_d = command_q;
    address_d = address_q;
    data0_d   = data0_q;
    data1_d   = data1_q;
    index_d   = index_q;
    irq_d     = irq_q;
    busy_d    = busy_q;
    blk_we    = 1'b0;
    blk_waddr = index_q;
    rd        = '0;
    start     = 1'b0;
    st        = status_q;

    case (item_i.kind)
      KIND_REG_WRITE: begin
        unique case (item_i.offset)
          REG_STATUS: begin
            irq_d = control_q[CT_IRQEN_BIT] &&
                    (|(item_i.value & ST_CLEARABLE & ~(status_q & ST_CLEARABLE)));
            status_d = (|(item_i.value & ST_CLEARABLE)) ? 8'h00 : ST_DONE;
            index_d  = '0;
          end
          REG_CONTROL: begin
            control_d = item_i.value;
            if (item_i.value[CT_ABORT_BIT]) begin
              st = st | ST_ABORT;
            end
            if (item_i.value[CT_START_BIT] && !busy_q) begin
              if (proto_ok) begin
                start  = 1'b1;
                busy_d = 1'b1;
              end else begin
                st = st | ST_PRERR;
                if (item_i.value[CT_IRQEN_BIT] && (|(st & ST_CLEARABLE))) begin
                  irq_d = 1'b1;
                end
              end
            end
            status_d = st;
          end
          REG_ADDRESS: address_d = item_i.value;
          REG_DATA0:   data0_d   = item_i.value;
          REG_DATA1:   data1_d   = item_i.value;
          REG_COMMAND: command_d = item_i.value;
          REG_BLOCK: begin
            blk_we  = 1'b1;
            index_d = index_next;
          end
          default: ;
        endcase
      end
      KIND_REG_READ: begin
        unique case (item_i.offset)
          REG_STATUS:  rd = status_q;
          REG_CONTROL: rd = control_q & CT_READ_MASK;
          REG_ADDRESS: rd = address_q;
          REG_DATA0:   rd = data0_q;
          REG_DATA1:   rd = data1_q;
          REG_COMMAND: rd = command_q;
          REG_BLOCK: begin
            rd      = blk_rdata;
            index_d = index_next;
          end
          default: rd = '0;
        endcase
      end
      KIND_BUS_DONE: begin
        if (busy_q) begin
          busy_d = 1'b0;
          if (!item_i.bus_ok) begin
            st = st | ST_PRERR;
          end else begin
            // Returned data only lands for read transactions.
            if (address_q[0]) begin
              if (control_q[2:0] == PROTO_WORD) begin
                data1_d = item_i.bus_data[15:8];
              end
              if (control_q[2:0] != PROTO_QUICK) begin
                data0_d = item_i.bus_data[7:0];
              end
            end
            st = st | ST_DONE;
          end
          status_d = st;
          if (control_q[CT_IRQEN_BIT] && (|(st & ST_CLEARABLE))) begin
            irq_d = 1'b1;
          end
        end
      end
      KIND_BUF_STORE: begin
        blk_we    = 1'b1;
        blk_waddr = item_i.buf_position;
      end
      KIND_BUF_FETCH: rd = blk_rdata;
      default: ;
    endcase
  end

  always_comb begin
    result_o = '0;
    result_o.read_data = rd;
    result_o.irq_level = irq_d;
    if (start) begin
      result_o.start_request = 1'b1;
      result_o.req_protocol  = control_d[2:0];
      result_o.req_device    = address_q[7:1];
      result_o.req_read      = address_q[0];
      result_o.req_command   = command_q;
      result_o.req_word      = {data1_q, data0_q};
      result_o.req_block_len = data0_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q  <= '0;
      control_q <= '0;
      command_q <= '0;
      address_q <= '0;
      data0_q   <= '0;
      data1_q   <= '0;
      index_q   <= '0;
      irq_q     <= 1'b0;
      busy_q    <= 1'b0;
    end else if (fire_i) begin
      status_q  <= status_d;
      control_q <= control_d;
      command_q <= command_d;
      address_q <= address_d;
      data0_q   <= data0_d;
      data1_q   <= data1_d;
      index_q   <= index_d;
      irq_q     <= irq_d;
      busy_q    <= busy_d;
    end
  end

  // The block buffer is small enough to live in flops cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BLOCK_BYTES; i++) begin
        blk_mem_q[i] <= '0;
      end
    end else if (fire_i && blk_we) begin
      blk_mem_q[blk_waddr] <= item_i.value;
    end
  end

endmodule

/* hw/rtl/smbus_host_controller_regs.sv */
// Top level of the SMBus host controller register file: stream ports,
// input register and result register around smbhc_regfile (smbhc_pkg).
//
//   Channel | Dir | Handshake               | Payload
//   --------+-----+-------------------------+-----------------------------------
//   s_axis  | in  | s_axis_tvalid/tready    | tuser: kind, tdata: access fields
//   m_axis  | out | m_axis_tvalid/tready    | tuser: start_request, tdata: result
//
// One beat is accepted every cycle unless the output stalls; each beat yields
// exactly one result beat. A beat sits in the input register, then updates the
// register file and loads the result register. Reset clears the valid flags,
// register file state and 32-byte block buffer at once, so no beat waits on a
// clearing pass. A stalled output holds its result; the input register keeps
// taking a beat while that result waits, then backs up the input side.
module smbus_host_controller_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [5:0] offset, [13:6] value, [14] bus_ok, [30:15] bus_data,
  // [35:31] buf_position, [39:36] zero
  input  logic [smbhc_pkg::S_DATA_W-1:0]   s_axis_tdata,
  // [2:0] kind
  input  logic [2:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [7:0] read_data, [8] irq_level, [11:9] req_protocol, [18:12] req_device,
  // [19] req_read, [27:20] req_command, [43:28] req_word,
  // [51:44] req_block_len, [55:52] zero
  output logic [smbhc_pkg::M_DATA_W-1:0]   m_axis_tdata,
  // [0] start_request
  output logic                             m_axis_tuser
);
  import smbhc_pkg::*;

  logic    in_vld_q;
  item_t   in_item_q;
  item_t   in_item_d;
  logic    out_vld_q;
  result_t out_res_q;
  result_t res;
  logic    s_accept;
  logic    fire;

  assign fire          = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || fire;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_item_d.kind         = kind_e'(s_axis_tuser);
    in_item_d.offset       = s_axis_tdata[5:0];
    in_item_d.value        = s_axis_tdata[13:6];
    in_item_d.bus_ok       = s_axis_tdata[14];
    in_item_d.bus_data     = s_axis_tdata[30:15];
    in_item_d.buf_position = s_axis_tdata[35:31];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_accept) begin
        in_vld_q <= 1'b1;
      end else if (fire) begin
        in_vld_q <= 1'b0;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_item_q <= in_item_d;
    end
    if (fire) begin
      out_res_q <= res;
    end
  end

  smbhc_regfile u_regfile (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (in_item_q),
    .result_o (res)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_res_q.start_request;
  assign m_axis_tdata  = {4'b0000,
                          out_res_q.req_block_len,
                          out_res_q.req_word,
                          out_res_q.req_command,
                          out_res_q.req_read,
                          out_res_q.req_device,
                          out_res_q.req_protocol,
                          out_res_q.irq_level,
                          out_res_q.read_data};

endmodule

/* hw/rtl/smbhc_checker.sv */
// Port-level checks for smbus_host_controller_regs, bound to the top level.
// Depends on smbhc_pkg for the stream widths and protocol codes.
module smbhc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [smbhc_pkg::S_DATA_W-1:0] s_axis_tdata,
  input logic [2:0]                     s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [smbhc_pkg::M_DATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tuser
);
  import smbhc_pkg::*;

  // A stalled result beat stays valid.
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload.
  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // A fresh result always traces back to an earlier accepted input beat.
  a_out_from_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result beat without an accepted input beat");

  // Request fields are zero unless a transaction is launched.
  a_req_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[51:9] == '0)
    else $error("request fields set without a start request");

  // Only supported protocols are ever launched.
  a_req_proto: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      (m_axis_tdata[11:9] <= PROTO_WORD) || (m_axis_tdata[11:9] == PROTO_BLOCK))
    else $error("unsupported protocol launched");

endmodule

bind smbus_host_controller_regs smbhc_checker u_smbhc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

/* dv/tb_smbus_host_controller_regs.sv */
// Testbench for smbus_host_controller_regs: drives register, completion and buffer beats
// through the input stream and checks every result beat against a cycle-free predictor.
// Depends on smbhc_pkg for widths, register offsets, status and control bit definitions.
`timescale 1ns / 1ps

module tb_smbus_host_controller_regs;
  import smbhc_pkg::*;

  localparam logic [2:0] PROTO_BYTE      = 3'd1;
  localparam logic [2:0] PROTO_BYTE_DATA = 3'd2;
  localparam logic [2:0] PROTO_PCALL     = 3'd4;
  localparam logic [2:0] PROTO_RSVD7     = 3'd7;
  localparam logic [5:0] OFF_LAST        = 6'd63;

  typedef struct packed {
    logic [2:0]  kind;
    logic [5:0]  offset;
    logic [7:0]  value;
    logic        bus_ok;
    logic [15:0] bus_data;
    logic [4:0]  buf_position;
  } bus_access_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata = '0;
  logic [2:0]          s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic                m_axis_tuser;

  smbus_host_controller_regs DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("tb_smbus_host_controller_regs NOT OK");
    $finish;
  end

  // Shadow copy of the controller registers, advanced once per accepted beat.
  logic [7:0]      hc_status = '0;
  logic [7:0]      hc_control = '0;
  logic [7:0]      hc_command = '0;
  logic [7:0]      hc_address = '0;
  logic [7:0]      hc_data_lo = '0;
  logic [7:0]      hc_data_hi = '0;
  logic [7:0]      hc_block_buf [BLOCK_BYTES] = '{default: 8'h00};
  logic [IDX_W-1:0] hc_block_idx = '0;
  logic            hc_irq = 1'b0;
  logic            hc_busy = 1'b0;

  result_t expected_replies [$];
  int unsigned error_count = 0;
  int unsigned src_idle_pct = 0;
  int unsigned sink_idle_pct = 0;

  function automatic void raise_if_pending();
    if (hc_control[CT_IRQEN_BIT] && ((hc_status & ST_CLEARABLE) != 8'h00))
      hc_irq = 1'b1;
  endfunction

  function automatic logic [7:0] block_port(logic wr, logic [7:0] v);
    logic [7:0] old;
    old = hc_block_buf[hc_block_idx];
    if (wr)
      hc_block_buf[hc_block_idx] = v;
    hc_block_idx = (hc_block_idx == IDX_W'(BLOCK_BYTES - 1)) ? '0 : hc_block_idx + 1'b1;
    return wr ? 8'h00 : old;
  endfunction

  function automatic result_t predict_reply(bus_access_t a);
    result_t r;
    logic [7:0] rd;
    logic launch;
    logic [2:0] proto;
    r = '0;
    rd = 8'h00;
    launch = 1'b0;
    case (a.kind)
      KIND_REG_WRITE: begin
        case (a.offset)
          REG_STATUS: begin
            // Only clearable bits that are not already pending can raise the line.
            hc_irq = hc_control[CT_IRQEN_BIT] &&
                     ((a.value & ST_CLEARABLE & ~hc_status) != 8'h00);
            hc_status = ((a.value & ST_CLEARABLE) != 8'h00) ? 8'h00 : ST_DONE;
            hc_block_idx = '0;
          end
          REG_CONTROL: begin
            hc_control = a.value;
            if (a.value[CT_ABORT_BIT])
              hc_status |= ST_ABORT;
            if (a.value[CT_START_BIT] && !hc_busy) begin
              proto = a.value[2:0];
              if (proto <= PROTO_WORD || proto == PROTO_BLOCK) begin
                launch = 1'b1;
                hc_busy = 1'b1;
              end else begin
                hc_status |= ST_PRERR;
                raise_if_pending();
              end
            end
          end
          REG_ADDRESS: hc_address = a.value;
          REG_DATA0:   hc_data_lo = a.value;
          REG_DATA1:   hc_data_hi = a.value;
          REG_COMMAND: hc_command = a.value;
          REG_BLOCK:   rd = block_port(1'b1, a.value);
          default: ;
        endcase
      end
      KIND_REG_READ: begin
        case (a.offset)
          REG_STATUS:  rd = hc_status;
          REG_CONTROL: rd = hc_control & CT_READ_MASK;
          REG_ADDRESS: rd = hc_address;
          REG_DATA0:   rd = hc_data_lo;
          REG_DATA1:   rd = hc_data_hi;
          REG_COMMAND: rd = hc_command;
          REG_BLOCK:   rd = block_port(1'b0, 8'h00);
          default:     rd = 8'h00;
        endcase
      end
      KIND_BUS_DONE: begin
        if (hc_busy) begin
          hc_busy = 1'b0;
          if (!a.bus_ok) begin
            hc_status |= ST_PRERR;
          end else begin
            proto = hc_control[2:0];
            // Returned data lands only for reads; quick commands carry none.
            if (hc_address[0]) begin
              if (proto == PROTO_WORD)
                hc_data_hi = a.bus_data[15:8];
              if (proto != PROTO_QUICK)
                hc_data_lo = a.bus_data[7:0];
            end
            hc_status |= ST_DONE;
          end
          raise_if_pending();
        end
      end
      KIND_BUF_STORE: hc_block_buf[a.buf_position] = a.value;
      KIND_BUF_FETCH: rd = hc_block_buf[a.buf_position];
      default: ;
    endcase
    r.read_data = rd;
    r.irq_level = hc_irq;
    if (launch) begin
      r.start_request = 1'b1;
      r.req_protocol  = hc_control[2:0];
      r.req_device    = hc_address[7:1];
      r.req_read      = hc_address[0];
      r.req_command   = hc_command;
      r.req_word      = {hc_data_hi, hc_data_lo};
      r.req_block_len = hc_data_lo;
    end
    return r;
  endfunction

  function automatic result_t observed_reply();
    result_t r;
    r.read_data     = m_axis_tdata[7:0];
    r.irq_level     = m_axis_tdata[8];
    r.start_request = m_axis_tuser;
    r.req_protocol  = m_axis_tdata[11:9];
    r.req_device    = m_axis_tdata[18:12];
    r.req_read      = m_axis_tdata[19];
    r.req_command   = m_axis_tdata[27:20];
    r.req_word      = m_axis_tdata[43:28];
    r.req_block_len = m_axis_tdata[51:44];
    return r;
  endfunction

  function automatic bus_access_t observed_access();
    bus_access_t a;
    a.kind         = s_axis_tuser;
    a.offset       = s_axis_tdata[5:0];
    a.value        = s_axis_tdata[13:6];
    a.bus_ok       = s_axis_tdata[14];
    a.bus_data     = s_axis_tdata[30:15];
    a.buf_position = s_axis_tdata[35:31];
    return a;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  function automatic void compare_reply(result_t want, result_t got);
    check_field("read_data", 16'(want.read_data), 16'(got.read_data));
    check_field("irq_level", 16'(want.irq_level), 16'(got.irq_level));
    check_field("start_request", 16'(want.start_request), 16'(got.start_request));
    check_field("req_protocol", 16'(want.req_protocol), 16'(got.req_protocol));
    check_field("req_device", 16'(want.req_device), 16'(got.req_device));
    check_field("req_read", 16'(want.req_read), 16'(got.req_read));
    check_field("req_command", 16'(want.req_command), 16'(got.req_command));
    check_field("req_word", want.req_word, got.req_word);
    check_field("req_block_len", 16'(want.req_block_len), 16'(got.req_block_len));
    check_field("tdata padding", 16'h0000, 16'(m_axis_tdata[M_DATA_W-1:52]));
  endfunction

  // Both handshakes are sampled with pre-edge values; output beats are checked
  // before the input beat of the same edge is predicted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_replies.size() == 0) begin
          $display("%0t ns: result beat expected none actual 0x%0h", $time, m_axis_tdata);
          error_count++;
        end else begin
          compare_reply(expected_replies.pop_front(), observed_reply());
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_replies.push_back(predict_reply(observed_access()));
    end
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  task automatic send_access(bus_access_t a);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, a.buf_position, a.bus_data, a.bus_ok, a.value, a.offset};
    s_axis_tuser  <= a.kind;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_replies_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_replies.size() != 0);
  endtask

  // Fields that the beat kind does not use still carry random values.
  function automatic bus_access_t any_access(logic [2:0] kind);
    bus_access_t a;
    a.kind         = kind;
    a.offset       = 6'($urandom_range(63));
    a.value        = 8'($urandom_range(255));
    a.bus_ok       = 1'($urandom_range(1));
    a.bus_data     = 16'($urandom_range(65535));
    a.buf_position = 5'($urandom_range(31));
    return a;
  endfunction

  function automatic logic [7:0] ctl_byte(logic [2:0] proto, logic start, logic irqen,
                                         logic abort);
    logic [7:0] v;
    v = '0;
    v[2:0] = proto;
    v[CT_START_BIT] = start;
    v[CT_IRQEN_BIT] = irqen;
    v[CT_ABORT_BIT] = abort;
    return v;
  endfunction

  function automatic logic [5:0] pick_offset();
    case ($urandom_range(9))
      0: return REG_STATUS;
      1: return REG_CONTROL;
      2: return REG_ADDRESS;
      3: return REG_DATA0;
      4: return REG_DATA1;
      5: return REG_COMMAND;
      6: return REG_BLOCK;
      default: return 6'($urandom_range(63));
    endcase
  endfunction

  function automatic logic [2:0] pick_protocol();
    if ($urandom_range(9) == 0)
      return 3'($urandom_range(7));
    case ($urandom_range(4))
      0: return PROTO_QUICK;
      1: return PROTO_BYTE;
      2: return PROTO_BYTE_DATA;
      3: return PROTO_WORD;
      default: return PROTO_BLOCK;
    endcase
  endfunction

  function automatic bus_access_t noise_access();
    bus_access_t a;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 30)      a = any_access(KIND_REG_WRITE);
    else if (pick < 60) a = any_access(KIND_REG_READ);
    else if (pick < 70) a = any_access(KIND_BUS_DONE);
    else if (pick < 80) a = any_access(KIND_BUF_STORE);
    else if (pick < 90) a = any_access(KIND_BUF_FETCH);
    else                a = any_access(3'($urandom_range(KIND_BUF_FETCH + 1, 7)));
    a.offset = pick_offset();
    return a;
  endfunction

  task automatic reg_write(logic [5:0] offset, logic [7:0] value);
    bus_access_t a;
    a = any_access(KIND_REG_WRITE);
    a.offset = offset;
    a.value = value;
    send_access(a);
  endtask

  task automatic reg_read(logic [5:0] offset);
    bus_access_t a;
    a = any_access(KIND_REG_READ);
    a.offset = offset;
    send_access(a);
  endtask

  task automatic bus_done(logic ok, logic [15:0] data);
    bus_access_t a;
    a = any_access(KIND_BUS_DONE);
    a.bus_ok = ok;
    a.bus_data = data;
    send_access(a);
  endtask

  task automatic buf_access(logic [2:0] kind, logic [4:0] pos, logic [7:0] value);
    bus_access_t a;
    a = any_access(kind);
    a.buf_position = pos;
    a.value = value;
    send_access(a);
  endtask

  task automatic test_directed();
    reg_read(REG_STATUS);
    reg_read(REG_BLOCK);
    reg_write(REG_ADDRESS, 8'hFF);
    reg_write(REG_COMMAND, 8'hFF);
    reg_write(REG_DATA0, 8'hFF);
    reg_write(REG_DATA1, 8'hFF);
    reg_write(REG_CONTROL, ctl_byte(PROTO_WORD, 1'b1, 1'b1, 1'b0));
    // A second start while the word read is outstanding launches nothing.
    reg_write(REG_CONTROL, ctl_byte(PROTO_WORD, 1'b1, 1'b1, 1'b0));
    bus_done(1'b1, 16'hFFFF);
    bus_done(1'b1, 16'h0000);
    reg_read(REG_DATA1);
    reg_read(REG_STATUS);
    reg_write(REG_STATUS, 8'h00);
    reg_write(REG_STATUS, 8'hFF);
    reg_write(REG_CONTROL, ctl_byte(PROTO_RSVD7, 1'b1, 1'b1, 1'b1) | 8'hC0);
    reg_read(REG_CONTROL);
    reg_write(REG_CONTROL, ctl_byte(PROTO_PCALL, 1'b1, 1'b0, 1'b0));
    reg_write(REG_ADDRESS, 8'h00);
    reg_write(REG_CONTROL, ctl_byte(PROTO_QUICK, 1'b1, 1'b0, 1'b0));
    bus_done(1'b0, 16'hFFFF);
    reg_write(OFF_LAST, 8'hFF);
    reg_read(OFF_LAST);
    buf_access(KIND_BUF_STORE, 5'd31, 8'hFF);
    buf_access(KIND_BUF_FETCH, 5'd31, 8'h00);
    for (int k = KIND_BUF_FETCH + 1; k < 8; k++)
      send_access(any_access(k[2:0]));
  endtask

  // Runs the data port past the end of the buffer so that the index wraps.
  task automatic test_block_port();
    reg_write(REG_STATUS, 8'($urandom_range(255)));
    repeat (BLOCK_BYTES + 2) reg_write(REG_BLOCK, 8'($urandom_range(255)));
    reg_write(REG_STATUS, 8'($urandom_range(255)));
    repeat (BLOCK_BYTES + 2) reg_read(REG_BLOCK);
  endtask

  task automatic test_transactions(int unsigned count);
    logic [7:0] ctl;
    repeat (count) begin
      reg_write(REG_ADDRESS, 8'($urandom_range(255)));
      reg_write(REG_COMMAND, 8'($urandom_range(255)));
      reg_write(REG_DATA0, 8'($urandom_range(255)));
      reg_write(REG_DATA1, 8'($urandom_range(255)));
      repeat ($urandom_range(3)) reg_write(REG_BLOCK, 8'($urandom_range(255)));
      ctl = ctl_byte(pick_protocol(), $urandom_range(15) != 0, 1'($urandom_range(1)),
                     $urandom_range(9) == 0);
      ctl[7:6] = 2'($urandom_range(3));
      reg_write(REG_CONTROL, ctl);
      repeat ($urandom_range(2)) send_access(noise_access());
      if ($urandom_range(7) == 0)
        wait_replies_drained();
      bus_done($urandom_range(9) != 0, 16'($urandom_range(65535)));
      reg_read(REG_STATUS);
      reg_read(REG_DATA0);
      reg_read(REG_DATA1);
      repeat ($urandom_range(2)) reg_read(REG_BLOCK);
      reg_write(REG_STATUS, 8'($urandom_range(255)));
    end
  endtask

  task automatic test_bus_buffer(int unsigned count);
    repeat (count)
      buf_access($urandom_range(1) ? KIND_BUF_STORE : KIND_BUF_FETCH,
                 5'($urandom_range(31)), 8'($urandom_range(255)));
  endtask

  task automatic test_noise(int unsigned count);
    repeat (count) send_access(noise_access());
  endtask

  initial begin
    src_idle_pct = 36;
    sink_idle_pct = 61;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    wait_replies_drained();
    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct  = (phase == 0) ? 36 : (phase == 1) ? 61 : 0;
      sink_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 36 : 0;
      test_block_port();
      test_transactions(32);
      test_bus_buffer(60);
      test_noise(110);
      wait_replies_drained();
    end
    repeat (8) @(posedge clk_i);
    if (error_count == 0 && expected_replies.size() == 0) begin
      $display("tb_smbus_host_controller_regs OK");
    end else begin
      $display("tb_smbus_host_controller_regs NOT OK");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/smbhc_pkg.sv
hw/rtl/smbhc_regfile.sv
hw/rtl/smbus_host_controller_regs.sv
hw/rtl/smbhc_checker.sv
dv/tb_smbus_host_controller_regs.sv
